>>> src/ebd_pkg.sv
`timescale 1ns / 1ps

package ebd_pkg;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } ebd_in_t;

    typedef struct packed {
        logic        beat_found;
        logic [42:0] block_energy;
    } ebd_out_t;

    localparam int APB_AW = 4;

    localparam logic [1:0] REG_BLOCK_LENGTH   = 2'd0;
    localparam logic [1:0] REG_HISTORY_LENGTH = 2'd1;
    localparam logic [1:0] REG_SENSITIVITY    = 2'd2;

    localparam logic [12:0] BLOCK_LENGTH_RESET   = 13'd1024;
    localparam logic [6:0]  HISTORY_LENGTH_RESET = 7'd43;
    localparam logic [15:0] SENSITIVITY_RESET    = 16'd333;

    localparam logic [42:0] ENERGY_OUT_MAX = {43{1'b1}};

endpackage

>>> src/energy_beat_detector_top.sv
`timescale 1ns / 1ps

// Sound-energy beat detector. Each transaction on the s_ channel carries one
// stereo pair of signed 16-bit samples; the block sums L*L+R*R over
// block_length pairs and, at the end of each block, emits one m_ transaction
// with the block energy and a beat flag. A beat is flagged when the block
// energy times history_length exceeds sensitivity (unsigned 8.8) times the
// running total of the last history_length block energies.
// One pair is accepted per cycle while s_ready is high. After the
// transaction that ends a block is accepted, the squares, the block
// accumulation with the history memory read, and the memory update with the
// threshold products are registered, then the compare goes into an
// eight-entry output queue that drives m_valid.
// The history memory is read and written once per block; a block that ends
// right after another one on the same entry takes the value by forwarding.
// After reset the history memory is cleared, one entry per cycle, through
// all MAX_HISTORY entries; s_ready stays low during that time. Configuration
// writes over the APB port are taken at any time. When the receiver stalls,
// results collect in the output queue and s_ready drops once the queued
// results and the transactions in the three pipeline stages fill the queue.
module energy_beat_detector_top
    import ebd_pkg::*;
#(
    parameter int MAX_HISTORY = 64,
    parameter int MAX_BLOCK   = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ebd_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ebd_out_t          m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int PW    = $clog2(MAX_HISTORY);
    localparam int CNTW  = $clog2(MAX_BLOCK);
    localparam int EW    = CNTW + 32;
    localparam int TW    = EW + PW;
    localparam int TH    = (TW + 1) / 2;
    localparam int BW    = $clog2(MAX_BLOCK + 1);
    localparam int LW0   = (BW > 13) ? BW : 13;
    localparam int LW    = (LW0 > CNTW + 1) ? LW0 : CNTW + 1;
    localparam int CW    = ((PW > 7) ? PW : 7) + 1;
    localparam int LHW   = EW + 7;
    localparam int CPW0  = LHW + 8;
    localparam int CPW   = (CPW0 > TW + 16) ? CPW0 : TW + 16;
    localparam int FDEPTH = 8;
    localparam int FAW   = $clog2(FDEPTH);

    // Configuration registers.
    logic [12:0] block_length_reg;
    logic [6:0]  history_length_reg;
    logic [15:0] sensitivity_reg;
    logic        cfg_we;

    // Clearing pass.
    logic          clearing_reg, clearing_next;
    logic [PW-1:0] clr_idx_reg, clr_idx_next;

    // Stage one: squares.
    logic            v1_reg, v1_next;
    logic            last1_reg;
    logic [30:0]     lsq_reg, rsq_reg;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            last_in;
    logic signed [31:0] lprod, rprod;

    // Stage two: block energy and memory read.
    logic          v2_reg, v2_next;
    logic [EW-1:0] acc_reg, acc_next;
    logic [EW-1:0] sum;
    logic [EW-1:0] e2_reg;
    logic [PW-1:0] waddr2_reg;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [PW-1:0] rd_addr, ptr_inc;
    logic          issue;
    logic          fwd_reg;
    logic [EW-1:0] fwd_data_reg;
    logic [EW-1:0] rd_data_reg;
    logic [EW-1:0] ring_mem [MAX_HISTORY];

    // Stage three: history update and threshold products.
    logic          v3_reg, v3_next;
    logic [TW-1:0] total_reg, total_next;
    logic [EW-1:0] old_e;
    logic [EW-1:0] e3_reg;
    logic [LHW-1:0]      lhs_reg;
    logic [TH+15:0]      plo_reg;
    logic [TW-TH+15:0]   phi_reg;
    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;

    // Compare and output queue.
    logic [CPW-1:0] lhs_full, rhs_full;
    ebd_out_t       push_data;
    ebd_out_t       fifo_mem [FDEPTH];
    logic [FAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FAW:0]   fifo_cnt_reg, fifo_cnt_next;
    logic [FAW+1:0] occupancy;
    logic           push, pop;

    logic [LW-1:0] blen_eff;
    logic [6:0]    hlen_eff;

    // APB port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_length_reg   <= BLOCK_LENGTH_RESET;
            history_length_reg <= HISTORY_LENGTH_RESET;
            sensitivity_reg    <= SENSITIVITY_RESET;
        end else if (cfg_we) begin
            case (paddr[APB_AW-1:2])
                REG_BLOCK_LENGTH:   block_length_reg   <= pwdata[12:0];
                REG_HISTORY_LENGTH: history_length_reg <= pwdata[6:0];
                REG_SENSITIVITY:    sensitivity_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[APB_AW-1:2])
            REG_BLOCK_LENGTH:   prdata = {19'd0, block_length_reg};
            REG_HISTORY_LENGTH: prdata = {25'd0, history_length_reg};
            REG_SENSITIVITY:    prdata = {16'd0, sensitivity_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_comb begin
        if (block_length_reg == 13'd0) begin
            blen_eff = LW'(1);
        end else if (LW'(block_length_reg) > LW'(MAX_BLOCK)) begin
            blen_eff = LW'(MAX_BLOCK);
        end else begin
            blen_eff = LW'(block_length_reg);
        end
        if (history_length_reg == 7'd0) begin
            hlen_eff = 7'd1;
        end else if (32'(history_length_reg) > MAX_HISTORY) begin
            hlen_eff = 7'(MAX_HISTORY);
        end else begin
            hlen_eff = history_length_reg;
        end
    end

    // Input side and stage one.
    assign occupancy = (FAW + 2)'(fifo_cnt_reg) + (FAW + 2)'(v1_reg)
                     + (FAW + 2)'(v2_reg) + (FAW + 2)'(v3_reg);
    assign s_ready   = !clearing_reg && (occupancy < (FAW + 2)'(FDEPTH));

    assign lprod   = s_data.left_sample * s_data.left_sample;
    assign rprod   = s_data.right_sample * s_data.right_sample;
    assign last_in = (LW'(cnt_reg) + LW'(1)) >= blen_eff;

    always_comb begin
        v1_next  = s_valid && s_ready;
        cnt_next = cnt_reg;
        if (v1_next) begin
            cnt_next = last_in ? '0 : cnt_reg + CNTW'(1);
        end
    end

    // Stage two.
    assign sum   = acc_reg + EW'(lsq_reg) + EW'(rsq_reg);
    assign issue = v1_reg && last1_reg;

    always_comb begin
        rd_addr  = (CW'(ptr_reg) >= CW'(hlen_eff)) ? '0 : ptr_reg;
        ptr_inc  = ((CW'(rd_addr) + CW'(1)) >= CW'(hlen_eff)) ? '0 : rd_addr + PW'(1);
        ptr_next = issue ? ptr_inc : ptr_reg;
        v2_next  = issue;
        acc_next = acc_reg;
        if (v1_reg) begin
            acc_next = last1_reg ? '0 : sum;
        end
    end

    // Stage three.
    assign old_e      = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign total_next = v2_reg ? (total_reg - TW'(old_e) + TW'(e2_reg)) : total_reg;
    assign v3_next    = v2_reg;

    assign mem_we    = clearing_reg || v2_reg;
    assign mem_waddr = clearing_reg ? clr_idx_reg : waddr2_reg;
    assign mem_wdata = clearing_reg ? '0 : e2_reg;

    always_comb begin
        clearing_next = clearing_reg;
        clr_idx_next  = clr_idx_reg;
        if (clearing_reg) begin
            clr_idx_next = clr_idx_reg + PW'(1);
            if (clr_idx_reg == PW'(MAX_HISTORY - 1)) begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    // Compare and output queue.
    assign lhs_full = CPW'(lhs_reg) << 8;
    assign rhs_full = CPW'(plo_reg) + (CPW'(phi_reg) << TH);

    always_comb begin
        push_data.beat_found = lhs_full > rhs_full;
        if (64'(e3_reg) > 64'(ENERGY_OUT_MAX)) begin
            push_data.block_energy = ENERGY_OUT_MAX;
        end else begin
            push_data.block_energy = 43'(e3_reg);
        end
    end

    assign push    = v3_reg;
    assign m_valid = fifo_cnt_reg != '0;
    assign pop     = m_valid && m_ready;
    assign m_data  = fifo_mem[rd_ptr_reg];

    always_comb begin
        fifo_cnt_next = fifo_cnt_reg;
        if (push && !pop) begin
            fifo_cnt_next = fifo_cnt_reg + (FAW + 1)'(1);
        end else if (pop && !push) begin
            fifo_cnt_next = fifo_cnt_reg - (FAW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            cnt_reg      <= '0;
            acc_reg      <= '0;
            ptr_reg      <= '0;
            total_reg    <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_idx_reg  <= clr_idx_next;
            v1_reg       <= v1_next;
            v2_reg       <= v2_next;
            v3_reg       <= v3_next;
            cnt_reg      <= cnt_next;
            acc_reg      <= acc_next;
            ptr_reg      <= ptr_next;
            total_reg    <= total_next;
            fifo_cnt_reg <= fifo_cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FAW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FAW'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (v1_next) begin
            lsq_reg   <= lprod[30:0];
            rsq_reg   <= rprod[30:0];
            last1_reg <= last_in;
        end
        if (issue) begin
            e2_reg       <= sum;
            waddr2_reg   <= rd_addr;
            fwd_reg      <= v2_reg && (waddr2_reg == rd_addr);
            fwd_data_reg <= e2_reg;
        end
        if (v2_reg) begin
            e3_reg  <= e2_reg;
            lhs_reg <= LHW'(e2_reg) * LHW'(hlen_eff);
            plo_reg <= (TH + 16)'(sensitivity_reg) * (TH + 16)'(total_reg[TH-1:0]);
            phi_reg <= (TW - TH + 16)'(sensitivity_reg)
                     * (TW - TH + 16)'(total_reg[TW-1:TH]);
        end
    end

    a_occupancy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy <= (FAW + 2)'(FDEPTH))
        else $error("results in flight exceed the output queue depth");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> (fifo_cnt_reg < (FAW + 1)'(FDEPTH)))
        else $error("output queue written while full");

    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_ready)
        else $error("transaction accepted during the history clearing pass");

    a_write_addr_in_history: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !clearing_reg) |-> (CW'(waddr2_reg) < CW'(hlen_eff)))
        else $error("history write outside the configured length");

    a_block_end_reaches_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |=> ##1 push)
        else $error("block end did not produce a result");

endmodule
